### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent |-> consequent, same edge
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent |=> consequent, next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### design/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Types, codes and the hex digit decoder for the HEX record loader.
// ----------------------------------------------------------------------------
package ihex_pkg;

  typedef logic [1:0] opcode_t;
  typedef logic [2:0] kind_t;

  // input opcodes
  localparam opcode_t OP_CHAR          = 2'd0;
  localparam opcode_t OP_RESTART       = 2'd1;
  localparam opcode_t OP_RESTART_COLON = 2'd2;

  // result kinds
  localparam kind_t KIND_WRITE     = 3'd0;
  localparam kind_t KIND_REC_OK    = 3'd1;
  localparam kind_t KIND_CSUM_ERR  = 3'd2;
  localparam kind_t KIND_END_OK    = 3'd3;
  localparam kind_t KIND_END_ERR   = 3'd4;
  localparam kind_t KIND_ABORT     = 3'd5;

  // record types
  localparam logic [7:0] REC_DATA     = 8'h00;
  localparam logic [7:0] REC_EOF      = 8'h01;
  localparam logic [7:0] REC_EXT_ADDR = 8'h04;

  localparam logic [7:0] COLON_CHAR = 8'h3A;

  // ASCII hex digit to nibble; anything else decodes as 15
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'hF;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

endpackage

### design/intel_hex_record_loader.sv
// ----------------------------------------------------------------------------
// intel_hex_record_loader
// Parses an ASCII HEX stream one character per word and emits memory writes
// and per-record status.
// ----------------------------------------------------------------------------
//
//  channel | signals                                    | dir | word
//  --------+--------------------------------------------+-----+-----------------
//  in      | in_valid, in_ready, opcode, char_in        | in  | one character
//  out     | out_valid, out_ready, kind, write_address, | out | write or status
//          | write_data, frame_number, error_count      |     |
//
//  One character per cycle: the parser state is updated in the accept cycle
//  and any result lands in the output register on the same edge.
//  in_ready = !out_valid | out_ready, so a held result only blocks input
//  while out_ready is low; nothing else stalls the parser.
//  At most one result per character; most characters give none.
//  rst (synchronous) or an in-band OP_RESTART clears all counters and the
//  address into wait-for-colon; OP_RESTART_COLON clears them into PH_COUNT.
//  Checksum-failing frames are reported through kind/frame_number results;
//  the frame log itself is kept by the consumer.
//
module intel_hex_record_loader #(
  parameter int MAX_ERRORS = 8
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  ihex_pkg::opcode_t  opcode,
  input  logic [7:0]         char_in,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output ihex_pkg::kind_t    kind,
  output logic [31:0]        write_address,
  output logic [15:0]        write_data,
  output logic [15:0]        frame_number,
  output logic [3:0]         error_count
);

  import ihex_pkg::*;

`include "assert_macros.svh"

  localparam int EW = $clog2(MAX_ERRORS + 1);

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_COUNT,
    PH_OFFSET,
    PH_TYPE,
    PH_DATA,
    PH_CHECK,
    PH_DONE
  } phase_t;

  // parser state
  phase_t        phase, phase_next;
  logic [1:0]    digit_counter, digit_counter_next;
  logic [7:0]    bytes_left, bytes_left_next;
  logic [7:0]    record_type, record_type_next;
  logic [31:0]   load_address, load_address_next;
  logic [7:0]    byte_sum, byte_sum_next;
  logic [15:0]   field_accumulator, field_accumulator_next;
  logic [15:0]   record_index, record_index_next;
  logic [EW-1:0] errors_logged, errors_logged_next;

  // result of the current character
  logic          res_valid;
  kind_t         res_kind;
  logic [31:0]   res_address;
  logic [15:0]   res_data;

  // scratch
  logic          in_fire;
  logic [3:0]    nib;
  logic [2:0]    d;
  logic [15:0]   acc_base;
  logic [15:0]   acc_shift;
  logic [7:0]    bl_dec;
  logic          is_eof;
  logic [7:0]    err_ext;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign nib = hex_nibble(char_in);
  assign d   = 3'(digit_counter) + 3'd1;

  always_comb begin
    phase_next             = phase;
    digit_counter_next     = digit_counter;
    bytes_left_next        = bytes_left;
    record_type_next       = record_type;
    load_address_next      = load_address;
    byte_sum_next          = byte_sum;
    field_accumulator_next = field_accumulator;
    record_index_next      = record_index;
    errors_logged_next     = errors_logged;
    res_valid              = 1'b0;
    res_kind               = KIND_WRITE;
    res_address            = '0;
    res_data               = '0;

    // data records restart the word each time the digit counter is back at zero
    acc_base  = (phase == PH_DATA && record_type == REC_DATA && digit_counter == 2'd0)
                ? 16'd0 : field_accumulator;
    acc_shift = {acc_base[11:0], nib};
    bl_dec    = bytes_left - 8'd1;
    is_eof    = (record_type == REC_EOF);

    if (opcode == OP_RESTART || opcode == OP_RESTART_COLON) begin
      phase_next             = (opcode == OP_RESTART_COLON) ? PH_COUNT : PH_WAIT;
      digit_counter_next     = '0;
      bytes_left_next        = '0;
      record_type_next       = '0;
      load_address_next      = '0;
      byte_sum_next          = '0;
      field_accumulator_next = '0;
      record_index_next      = '0;
      errors_logged_next     = '0;
    end else if (opcode == OP_CHAR) begin
      unique case (phase)
        PH_WAIT: begin
          if (char_in == COLON_CHAR) begin
            phase_next             = PH_COUNT;
            digit_counter_next     = '0;
            field_accumulator_next = '0;
            byte_sum_next          = '0;
          end
        end
        PH_COUNT: begin
          field_accumulator_next = acc_shift;
          digit_counter_next     = d[1:0];
          if (d == 3'd2) begin
            bytes_left_next        = acc_shift[7:0];
            byte_sum_next          = byte_sum + acc_shift[7:0];
            field_accumulator_next = '0;
            digit_counter_next     = '0;
            phase_next             = PH_OFFSET;
          end
        end
        PH_OFFSET: begin
          field_accumulator_next = acc_shift;
          digit_counter_next     = d[1:0];
          if (d == 3'd4) begin
            load_address_next      = {load_address[31:16], acc_shift};
            byte_sum_next          = byte_sum + acc_shift[15:8] + acc_shift[7:0];
            field_accumulator_next = '0;
            phase_next             = PH_TYPE;
          end
        end
        PH_TYPE: begin
          field_accumulator_next = acc_shift;
          digit_counter_next     = d[1:0];
          if (d == 3'd2) begin
            record_type_next       = acc_shift[7:0];
            byte_sum_next          = byte_sum + acc_shift[7:0];
            field_accumulator_next = '0;
            digit_counter_next     = '0;
            if (bytes_left == 8'd0) begin
              // empty record: extended address with no data clears the upper half
              if (acc_shift[7:0] == REC_EXT_ADDR) begin
                load_address_next = {16'd0, load_address[15:0]};
              end
              phase_next = PH_CHECK;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          field_accumulator_next = acc_shift;
          digit_counter_next     = d[1:0];
          if (d == 3'd2 || d == 3'd4) begin
            byte_sum_next   = byte_sum + acc_shift[7:0];
            bytes_left_next = bl_dec;
            if (record_type == REC_DATA && (d == 3'd4 || bl_dec == 8'd0)) begin
              res_valid          = 1'b1;
              res_kind           = KIND_WRITE;
              res_address        = load_address;
              res_data           = acc_shift;
              load_address_next  = load_address + 32'd1;
              digit_counter_next = '0;
            end
            if (bl_dec == 8'd0) begin
              if (record_type == REC_EXT_ADDR) begin
                load_address_next = {acc_shift, load_address[15:0]};
              end
              phase_next             = PH_CHECK;
              digit_counter_next     = '0;
              field_accumulator_next = '0;
            end
          end
        end
        PH_CHECK: begin
          field_accumulator_next = acc_shift;
          digit_counter_next     = d[1:0];
          if (d == 3'd2) begin
            digit_counter_next     = '0;
            field_accumulator_next = '0;
            res_valid              = 1'b1;
            if (acc_shift[7:0] != 8'(-byte_sum)) begin
              if (errors_logged < EW'(MAX_ERRORS)) begin
                errors_logged_next = errors_logged + EW'(1);
                res_kind           = is_eof ? KIND_END_ERR : KIND_CSUM_ERR;
                record_index_next  = record_index + 16'd1;
                phase_next         = is_eof ? PH_DONE : PH_WAIT;
              end else begin
                // error budget spent: stop, keep the frame index
                res_kind   = KIND_ABORT;
                phase_next = PH_DONE;
              end
            end else begin
              res_kind          = is_eof ? KIND_END_OK : KIND_REC_OK;
              record_index_next = record_index + 16'd1;
              phase_next        = is_eof ? PH_DONE : PH_WAIT;
            end
          end
        end
        PH_DONE: begin
          // hold until restart
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end

    err_ext = 8'(errors_logged_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_WAIT;
      digit_counter     <= '0;
      bytes_left        <= '0;
      record_type       <= '0;
      load_address      <= '0;
      byte_sum          <= '0;
      field_accumulator <= '0;
      record_index      <= '0;
      errors_logged     <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (in_fire) begin
        phase             <= phase_next;
        digit_counter     <= digit_counter_next;
        bytes_left        <= bytes_left_next;
        record_type       <= record_type_next;
        load_address      <= load_address_next;
        byte_sum          <= byte_sum_next;
        field_accumulator <= field_accumulator_next;
        record_index      <= record_index_next;
        errors_logged     <= errors_logged_next;
      end
      if (in_fire && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      kind          <= res_kind;
      write_address <= res_address;
      write_data    <= res_data;
      frame_number  <= record_index;
      error_count   <= (err_ext > 8'd15) ? 4'd15 : err_ext[3:0];
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `ASSERT_IMPLY(a_err_bound, clk, rst, 1'b1, errors_logged <= EW'(MAX_ERRORS), "error count past limit")
  `ASSERT_IMPLY(a_stall_only_on_out, clk, rst, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")
  `ASSERT_NEXT(a_restart_clears, clk, rst, in_fire && (opcode == OP_RESTART || opcode == OP_RESTART_COLON), record_index == 16'd0 && errors_logged == '0, "restart did not clear counters")
  `ASSERT_NEXT(a_abort_stops, clk, rst, in_fire && res_valid && res_kind == KIND_ABORT, phase == PH_DONE && out_valid, "abort did not stop parser")
  `ASSERT_NEXT(a_addr_step, clk, rst, in_fire && res_valid && res_kind == KIND_WRITE, load_address == $past(load_address) + 32'd1, "write address did not advance")

endmodule
